[design/mau_pkg.sv]
package mau_pkg;

    localparam int Dim       = 4;
    localparam int FracBits  = 16;
    localparam int Cells     = Dim * Dim;
    localparam int IdxW      = $clog2(Cells);
    localparam int KW        = $clog2(Dim);

    localparam logic [3:0] CMD_WR_OPD = 4'd0;
    localparam logic [3:0] CMD_WR_ACC = 4'd1;
    localparam logic [3:0] CMD_IDENT  = 4'd2;
    localparam logic [3:0] CMD_CLEAR  = 4'd3;
    localparam logic [3:0] CMD_ADD    = 4'd4;
    localparam logic [3:0] CMD_SUB    = 4'd5;
    localparam logic [3:0] CMD_MATMUL = 4'd6;
    localparam logic [3:0] CMD_SCALE  = 4'd7;
    localparam logic [3:0] CMD_DIVIDE = 4'd8;
    localparam logic [3:0] CMD_READ   = 4'd9;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               status;
    } t_out_item;

    // datapath operations issued by the controller
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ELEM  = 3'd1; // write/identity/clear, or per-element op on acc[i]
    localparam logic [2:0] OP_MAC   = 3'd2; // one product of matmul
    localparam logic [2:0] OP_DIVST = 3'd3; // start a divide of acc[i]

    typedef struct packed {
        logic [2:0]      op;
        logic [3:0]      cmd;
        logic [IdxW-1:0] idx;
        logic [KW-1:0]   k;
        logic            first;   // first product of a matmul cell; with OP_NONE, latch the scalar
        logic            last;    // last product of a matmul cell
        logic            commit;  // copy the matmul buffer into the accumulator
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic mac_busy;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

[design/mau_div.sv]
// Serial restoring divider: magnitude of (a << FracBits) by magnitude of d,
// one quotient bit per cycle, then round half away from zero and saturate.
module mau_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_d,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_q
);
    localparam int NW = 32 + mau_pkg::FracBits;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, r_done;
    logic [33:0]   w_trial;
    logic [NW:0]   w_rq;
    logic signed [65:0] w_sq;

    assign w_trial = {r_rem, r_num[NW-1]} - {2'b0, r_den};

    always_comb begin
        n_rem = {r_rem[31:0], r_num[NW-1]};
        n_num = {r_num[NW-2:0], 1'b0};
        if (!w_trial[33]) begin
            n_rem = w_trial[32:0];
            n_num[0] = 1'b1;
        end
        n_cnt = r_cnt - CW'(1);
    end

    // round: remainder*2 >= divisor bumps the magnitude
    assign w_rq = {1'b0, r_num} + {{NW{1'b0}}, ({r_rem, 1'b0} >= {2'b0, r_den})};
    assign w_sq = r_neg ? -$signed({{(65 - NW){1'b0}}, w_rq})
                        : $signed({{(65 - NW){1'b0}}, w_rq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_num  <= {(i_a[31] ? 32'(-i_a) : 32'(i_a)),
                           {mau_pkg::FracBits{1'b0}}};
                r_den  <= i_d[31] ? 32'(-i_d) : 32'(i_d);
                r_neg  <= i_a[31] ^ i_d[31];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_cnt <= n_cnt;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = mau_pkg::sat32(w_sq);
endmodule

[design/mau_datapath.sv]
module mau_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mau_pkg::t_dp_cmd    i_cmd,
    input  mau_pkg::t_in_item   i_item,
    output mau_pkg::t_dp_sts    o_sts,
    output logic signed [31:0]  o_rd
);
    localparam int Cells = mau_pkg::Cells;
    localparam int Dim   = mau_pkg::Dim;
    localparam int Fb    = mau_pkg::FracBits;
    localparam int KW    = mau_pkg::KW;
    localparam int IdxW  = mau_pkg::IdxW;

    logic signed [31:0] r_acc [Cells];
    logic signed [31:0] r_opd [Cells];
    logic signed [31:0] r_tmp [Cells];

    logic [KW-1:0] w_x, w_y;
    logic signed [31:0] w_a, w_b, w_s;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] r_prod;
    logic               r_pv, r_plast;
    logic [IdxW-1:0]    r_pidx;
    logic signed [65:0] r_sum;
    logic signed [31:0] r_scalar;
    logic [IdxW-1:0]    r_didx;
    logic               w_dbusy, w_ddone;
    logic signed [31:0] w_dq;
    logic signed [65:0] w_tot, w_e;

    assign w_x = i_cmd.idx[IdxW-1 -: KW];
    assign w_y = i_cmd.idx[KW-1:0];
    assign w_a = r_acc[{w_x, i_cmd.k}];
    assign w_b = r_opd[{i_cmd.k, w_y}];
    assign w_s = r_acc[i_cmd.idx];

    // one shared multiplier: matmul term, or acc element times scalar
    assign w_ma = (i_cmd.op == mau_pkg::OP_MAC) ? w_a : w_s;
    assign w_mb = (i_cmd.op == mau_pkg::OP_MAC) ? w_b : r_scalar;

    mau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.op == mau_pkg::OP_DIVST),
        .i_a(w_s), .i_d(r_scalar),
        .o_busy(w_dbusy), .o_done(w_ddone), .o_q(w_dq)
    );

    // exact sum of products, rounded half up at the end
    assign w_tot = r_sum + 66'(r_prod);

    always_comb begin
        w_e = 66'(w_s);
        case (i_cmd.cmd)
            mau_pkg::CMD_ADD:   w_e = 66'(w_s) + 66'(r_opd[i_cmd.idx]);
            mau_pkg::CMD_SUB:   w_e = 66'(w_s) - 66'(r_opd[i_cmd.idx]);
            mau_pkg::CMD_SCALE: w_e = (66'(r_prod) + 66'(1 << (Fb - 1))) >>> Fb;
            mau_pkg::CMD_DIVIDE: begin
                if (w_s > 0) w_e = 66'sd2147483647;
                else if (w_s < 0) w_e = -66'sd2147483648;
            end
            default: w_e = 66'(w_s);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Cells; i++) begin
                r_acc[i] <= '0;
                r_opd[i] <= '0;
            end
            r_pv <= 1'b0;
        end else begin
            // multiplier stage
            r_pv    <= (i_cmd.op == mau_pkg::OP_MAC);
            r_plast <= i_cmd.last;
            r_pidx  <= i_cmd.idx;
            r_prod  <= 64'(w_ma) * 64'(w_mb);
            if (i_cmd.op == mau_pkg::OP_MAC && i_cmd.first) r_sum <= '0;
            else if (r_pv) r_sum <= w_tot;
            if (r_pv && r_plast)
                r_tmp[r_pidx] <= mau_pkg::sat32((w_tot + 66'(1 << (Fb - 1))) >>> Fb);
            if (i_cmd.commit)
                for (int i = 0; i < Cells; i++) r_acc[i] <= r_tmp[i];
            if (i_cmd.op == mau_pkg::OP_DIVST) r_didx <= i_cmd.idx;
            if (w_ddone) r_acc[r_didx] <= w_dq;
            if (i_cmd.op == mau_pkg::OP_ELEM) begin
                case (i_cmd.cmd)
                    mau_pkg::CMD_WR_OPD:
                        r_opd[{i_item.row, i_item.col}] <= i_item.value;
                    mau_pkg::CMD_WR_ACC:
                        r_acc[{i_item.row, i_item.col}] <= i_item.value;
                    mau_pkg::CMD_IDENT:
                        for (int i = 0; i < Cells; i++)
                            r_acc[i] <= (i / Dim == i % Dim) ? 32'(1 << Fb) : '0;
                    mau_pkg::CMD_CLEAR:
                        for (int i = 0; i < Cells; i++) r_acc[i] <= '0;
                    mau_pkg::CMD_READ: ;
                    default: r_acc[i_cmd.idx] <= mau_pkg::sat32(w_e);
                endcase
            end
            if (i_cmd.op == mau_pkg::OP_NONE && i_cmd.first) r_scalar <= i_item.value;
        end
    end

    assign o_rd = r_acc[{i_item.row, i_item.col}];
    assign o_sts.div_busy = w_dbusy | w_ddone;
    assign o_sts.mac_busy = r_pv;
endmodule

[design/mau_ctrl.sv]
module mau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mau_pkg::t_in_item i_item,
    output mau_pkg::t_dp_cmd  o_cmd,
    input  mau_pkg::t_dp_sts  i_sts,
    input  logic signed [31:0] i_rd,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mau_pkg::t_out_item o_out
);
    localparam int IdxW = mau_pkg::IdxW;
    localparam int KW   = mau_pkg::KW;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAL  = 3'd1; // scale: multiply then write
    localparam logic [2:0] S_ELEM  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;

    logic [2:0]      r_state;
    logic [IdxW-1:0] r_idx;
    logic [KW-1:0]   r_k;
    logic [3:0]      r_cmd;
    logic            r_ov;
    mau_pkg::t_out_item r_out;
    logic            w_acc;
    logic            w_oc;

    assign w_oc = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_oc;
    assign w_acc = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd = '0;
        o_cmd.cmd = r_cmd;
        o_cmd.idx = r_idx;
        o_cmd.k   = r_k;
        case (r_state)
            S_IDLE: begin
                o_cmd.cmd = i_item.cmd;
                o_cmd.first = w_acc; // latch scalar
                if (w_acc && (i_item.cmd inside {mau_pkg::CMD_WR_OPD, mau_pkg::CMD_WR_ACC,
                                                 mau_pkg::CMD_IDENT, mau_pkg::CMD_CLEAR}))
                    o_cmd.op = mau_pkg::OP_ELEM;
            end
            S_ELEM:  o_cmd.op = mau_pkg::OP_ELEM;
            S_MAC: begin
                o_cmd.op    = mau_pkg::OP_MAC;
                o_cmd.first = (r_k == '0);
                o_cmd.last  = (r_k == KW'(mau_pkg::Dim - 1));
            end
            S_DRAIN: o_cmd.commit = !i_sts.mac_busy;
            S_DIV:   o_cmd.op = mau_pkg::OP_DIVST;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_k     <= '0;
            r_cmd   <= '0;
        end else begin
            if (w_acc) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (w_acc) begin
                    r_cmd <= i_item.cmd;
                    r_idx <= '0;
                    r_k   <= '0;
                    r_out.read_value <= (i_item.cmd == mau_pkg::CMD_READ) ? i_rd : '0;
                    r_out.status <= (i_item.cmd == mau_pkg::CMD_DIVIDE) &&
                                    (i_item.value == '0);
                    case (i_item.cmd)
                        mau_pkg::CMD_ADD, mau_pkg::CMD_SUB: r_state <= S_ELEM;
                        mau_pkg::CMD_SCALE:  r_state <= S_SCAL;
                        mau_pkg::CMD_MATMUL: r_state <= S_MAC;
                        mau_pkg::CMD_DIVIDE:
                            r_state <= (i_item.value == '0) ? S_ELEM : S_DIV;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCAL: r_state <= S_ELEM;  // product registered for r_idx
                S_ELEM: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IdxW'(mau_pkg::Cells - 1)) r_state <= S_IDLE;
                    else if (r_cmd == mau_pkg::CMD_SCALE) r_state <= S_SCAL;
                end
                S_MAC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(mau_pkg::Dim - 1)) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == IdxW'(mau_pkg::Cells - 1)) r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: if (!i_sts.mac_busy) r_state <= S_IDLE;
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: if (!i_sts.div_busy) begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= (r_idx == IdxW'(mau_pkg::Cells - 1)) ? S_IDLE : S_DIV;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule

[design/matrix4x4_arithmetic_unit.sv]
// Latency: the result transaction is offered the cycle after the command is taken.
// Write/read/identity/clear complete in idle; add/sub walk each cell; scale
// multiplies then writes; matmul runs 64 products on one shared multiplier, then
// drains; divide runs the serial divider per element unless the divisor is 0.
// Reset (synchronous, active low) zeroes both matrices and idles the controller.
module matrix4x4_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mau_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output mau_pkg::t_out_item o_item
);
    // command and status between sequencer and datapath
    mau_pkg::t_dp_cmd   w_cmd;
    mau_pkg::t_dp_sts   w_sts;
    logic signed [31:0] w_rd;

    mau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_stall(o_stall), .i_item(i_item),
        .o_cmd(w_cmd), .i_sts(w_sts), .i_rd(w_rd),
        .o_out_valid(o_valid), .i_out_stall(i_stall), .o_out(o_item)
    );

    mau_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_item(i_item), .o_sts(w_sts), .o_rd(w_rd)
    );
endmodule

[design/mau_checker.sv]
module mau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input mau_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input mau_pkg::t_out_item o_item
);
    // every accepted transaction raises a result next cycle
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid) else $error("no result");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item)) else $error("result moved");
    // zero divide flags status
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.cmd == mau_pkg::CMD_DIVIDE && i_item.value == 0
        |=> o_item.status) else $error("no div0 flag");
    // non-read commands return zero
    a_rz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.cmd != mau_pkg::CMD_READ
        |=> o_item.read_value == 0) else $error("nonzero read");
endmodule

bind matrix4x4_arithmetic_unit mau_checker u_chk (.*);
